>>> rtl/cwse_pkg.sv
`default_nettype none
package cwse_pkg;

  localparam int FRAC_BITS    = 12;
  localparam int CORDIC_STEPS = 16;

  localparam int TWOF      = 2 * FRAC_BITS;
  localparam int ANG_UP    = (TWOF <= 30) ? 30 - TWOF : 0;
  localparam int ANG_DN    = (TWOF > 30) ? TWOF - 30 : 0;
  localparam int MOD_W     = 32 + ANG_UP;
  localparam int RED_STEPS = (MOD_W > 32) ? MOD_W - 32 : 0;
  localparam int PH_W      = 35;
  localparam int CW        = 34;
  localparam int NU_W      = 49;
  localparam int DQ_W      = 50 - FRAC_BITS;

  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint TWO_PI_Q30  = 64'd6746518852;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint GAIN_Q30    = 64'd652032874;

  localparam logic [15:0] NORM_ONE =
      ((64'd1 << FRAC_BITS) > 64'd65535) ? 16'hFFFF : 16'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {
    REG_AMPLITUDE      = 2'd0,
    REG_FREQUENCY      = 2'd1,
    REG_NEAR_THRESHOLD = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] u_coord;
    logic signed [15:0] v_coord;
  } item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        radius;
    logic signed [31:0] tan_u_z;
    logic signed [31:0] tan_v_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic [15:0]        norm_z;
    logic               near_center;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] qsat(input logic neg, input logic [63:0] q);
    if (!neg) begin
      if (q > 64'd2147483647) return 32'sh7FFFFFFF;
      return 32'(q);
    end
    if (q > 64'd2147483648) return 32'sh80000000;
    return 32'(-q);
  endfunction

  function automatic logic [30:0] atan_q30(input int k);
    logic [30:0] r;
    unique case (k)
      0:  r = 31'd843314856;
      1:  r = 31'd497837829;
      2:  r = 31'd263043836;
      3:  r = 31'd133525158;
      4:  r = 31'd67021686;
      5:  r = 31'd33543515;
      6:  r = 31'd16775850;
      7:  r = 31'd8388437;
      8:  r = 31'd4194282;
      9:  r = 31'd2097149;
      10: r = 31'd1048575;
      11: r = 31'd524287;
      12: r = 31'd262143;
      13: r = 31'd131071;
      14: r = 31'd65535;
      15: r = 31'd32767;
      16: r = 31'd16383;
      17: r = 31'd8191;
      18: r = 31'd4095;
      19: r = 31'd2047;
      20: r = 31'd1023;
      21: r = 31'd511;
      22: r = 31'd255;
      23: r = 31'd127;
      24: r = 31'd63;
      25: r = 31'd31;
      26: r = 31'd15;
      27: r = 31'd7;
      28: r = 31'd3;
      29: r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/cwse_sqrt.sv
`default_nettype none
module cwse_sqrt #(
  parameter int SW = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] n,
  input  logic [SW-1:0] side_in,
  output logic        out_valid,
  output logic [15:0] root,
  output logic [SW-1:0] side_out
);
  import cwse_pkg::*;

  logic          sv   [0:16];
  logic [31:0]   srem [0:16];
  logic [15:0]   sroot[0:16];
  logic [SW-1:0] sside[0:16];

  assign sv[0]    = in_valid;
  assign srem[0]  = n;
  assign sroot[0] = 16'd0;
  assign sside[0] = side_in;

  for (genvar g = 0; g < 16; g++) begin : g_bit
    localparam int SH = 15 - g;
    logic [32:0] trial;
    logic        take;
    assign trial = (33'(sroot[g]) << (SH + 1)) + (33'd1 << (2 * SH));
    assign take  = {1'b0, srem[g]} >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g+1] <= 1'b0;
      end else begin
        sv[g+1] <= sv[g];
      end
      srem[g+1]  <= take ? 32'({1'b0, srem[g]} - trial) : srem[g];
      sroot[g+1] <= take ? (sroot[g] | (16'd1 << SH)) : sroot[g];
      sside[g+1] <= sside[g];
    end
  end

  assign out_valid = sv[16];
  assign root      = sroot[16];
  assign side_out  = sside[16];

endmodule
`default_nettype wire

>>> rtl/cwse_angle.sv
`default_nettype none
module cwse_angle #(
  parameter int STEPS = cwse_pkg::CORDIC_STEPS,
  parameter int SW    = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [32:0]                theta,
  input  logic [SW-1:0]                     side_in,
  output logic                              out_valid,
  output logic signed [cwse_pkg::CW-1:0]    cos_q,
  output logic signed [cwse_pkg::CW-1:0]    sin_q,
  output logic [SW-1:0]                     side_out
);
  import cwse_pkg::*;

  localparam logic signed [PH_W-1:0] PI_P      = PH_W'(PI_Q30);
  localparam logic signed [PH_W-1:0] TWO_PI_P  = PH_W'(TWO_PI_Q30);
  localparam logic signed [PH_W-1:0] HALF_PI_P = PH_W'(HALF_PI_Q30);

  logic [31:0] mag;
  assign mag = 32'(theta[32] ? -theta : theta);

  logic             red_v   [0:RED_STEPS];
  logic             red_neg [0:RED_STEPS];
  logic [MOD_W-1:0] red_m   [0:RED_STEPS];
  logic [SW-1:0]    red_side[0:RED_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      red_v[0] <= 1'b0;
    end else begin
      red_v[0] <= in_valid;
    end
    red_neg[0]  <= theta[32];
    red_m[0]    <= MOD_W'((MOD_W'(mag) << ANG_UP) >> ANG_DN);
    red_side[0] <= side_in;
  end

  for (genvar g = 0; g < RED_STEPS; g++) begin : g_red
    localparam logic [MOD_W-1:0] SUB = MOD_W'(TWO_PI_Q30 << (RED_STEPS - 1 - g));
    always_ff @(posedge clk) begin
      if (rst) begin
        red_v[g+1] <= 1'b0;
      end else begin
        red_v[g+1] <= red_v[g];
      end
      red_neg[g+1]  <= red_neg[g];
      red_m[g+1]    <= (red_m[g] >= SUB) ? red_m[g] - SUB : red_m[g];
      red_side[g+1] <= red_side[g];
    end
  end

  logic signed [CW-1:0]   cx   [0:STEPS];
  logic signed [CW-1:0]   cy   [0:STEPS];
  logic signed [PH_W-1:0] cp   [0:STEPS];
  logic                   cv   [0:STEPS];
  logic [SW+1:0]          cside[0:STEPS];

  logic signed [PH_W-1:0] p_wrap;
  logic signed [PH_W-1:0] p_fold;
  logic                   flip;

  always_comb begin
    p_wrap = PH_W'(red_m[RED_STEPS]);
    if (p_wrap > PI_P) begin
      p_wrap = p_wrap - TWO_PI_P;
    end
    flip = 1'b0;
    p_fold = p_wrap;
    if (p_wrap > HALF_PI_P) begin
      p_fold = p_wrap - PI_P;
      flip = 1'b1;
    end else if (p_wrap < -HALF_PI_P) begin
      p_fold = p_wrap + PI_P;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= red_v[RED_STEPS];
    end
    cx[0]    <= CW'(GAIN_Q30);
    cy[0]    <= '0;
    cp[0]    <= p_fold;
    cside[0] <= {red_neg[RED_STEPS], flip, red_side[RED_STEPS]};
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [PH_W-1:0] ATAN = PH_W'(atan_q30(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
      if (cp[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cp[i+1] <= cp[i] - ATAN;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cp[i+1] <= cp[i] + ATAN;
      end
      cside[i+1] <= cside[i];
    end
  end

  logic f_neg, f_flip;
  assign f_neg  = cside[STEPS][SW+1];
  assign f_flip = cside[STEPS][SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cv[STEPS];
    end
    cos_q    <= f_flip ? -cx[STEPS] : cx[STEPS];
    sin_q    <= (f_flip ^ f_neg) ? -cy[STEPS] : cy[STEPS];
    side_out <= cside[STEPS][SW-1:0];
  end

endmodule
`default_nettype wire

>>> rtl/cwse_div.sv
`default_nettype none
module cwse_div #(
  parameter int NW = 38,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num_a,
  input  logic [NW-1:0] num_b,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo_a,
  output logic [NW-1:0] quo_b,
  output logic [SW-1:0] side_out
);
  import cwse_pkg::*;

  logic          dv   [0:NW];
  logic [NW-1:0] na   [0:NW];
  logic [NW-1:0] nb   [0:NW];
  logic [NW-1:0] qa   [0:NW];
  logic [NW-1:0] qb   [0:NW];
  logic [DW-1:0] ra   [0:NW];
  logic [DW-1:0] rb   [0:NW];
  logic [DW-1:0] dd   [0:NW];
  logic [SW-1:0] dside[0:NW];

  assign dv[0]    = in_valid;
  assign na[0]    = num_a;
  assign nb[0]    = num_b;
  assign qa[0]    = '0;
  assign qb[0]    = '0;
  assign ra[0]    = '0;
  assign rb[0]    = '0;
  assign dd[0]    = den;
  assign dside[0] = side_in;

  for (genvar g = 0; g < NW; g++) begin : g_step
    logic [DW:0] ta, tb;
    logic        ka, kb;
    assign ta = {ra[g], na[g][NW-1]};
    assign tb = {rb[g], nb[g][NW-1]};
    assign ka = ta >= {1'b0, dd[g]};
    assign kb = tb >= {1'b0, dd[g]};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[g+1] <= 1'b0;
      end else begin
        dv[g+1] <= dv[g];
      end
      na[g+1]    <= na[g] << 1;
      nb[g+1]    <= nb[g] << 1;
      ra[g+1]    <= ka ? DW'(ta - {1'b0, dd[g]}) : DW'(ta);
      rb[g+1]    <= kb ? DW'(tb - {1'b0, dd[g]}) : DW'(tb);
      qa[g+1]    <= {qa[g][NW-2:0], ka};
      qb[g+1]    <= {qb[g][NW-2:0], kb};
      dd[g+1]    <= dd[g];
      dside[g+1] <= dside[g];
    end
  end

  assign out_valid = dv[NW];
  assign quo_a     = qa[NW];
  assign quo_b     = qb[NW];
  assign side_out  = dside[NW];

endmodule
`default_nettype wire

>>> rtl/cosine_wave_surface_eval.sv
// Channel  | Signals                              | Handshake
// input    | start, busy, item                    | taken when start && !busy
// config   | cfg_valid, cfg_ready, cfg_index/data | written when cfg_valid && cfg_ready
// result   | done, result                         | one cycle per strobe, no back-pressure
//
// One transaction enters every cycle while busy is low; busy is high only during reset.
// The pipeline holds 3 front stages, 16 root bits, 1 angle multiply,
// 3 + RED_STEPS + CORDIC_STEPS angle stages, 4 product stages,
// DQ_W (50 - FRAC_BITS) divider bits and the output register.
// rst clears every valid bit and loads the register defaults.
`default_nettype none
module cosine_wave_surface_eval #(
  parameter int CORDIC_STEPS = cwse_pkg::CORDIC_STEPS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cwse_pkg::item_t   item,
  output logic              done,
  output cwse_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import cwse_pkg::*;

  typedef struct packed {
    item_t       item;
    logic [15:0] radius;
  } geo_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        radius;
    logic signed [31:0] tan_u_z;
    logic signed [31:0] tan_v_z;
    logic signed [31:0] nx_near;
    logic signed [31:0] ny_near;
    logic               near;
    logic               neg_x;
    logic               neg_y;
  } mid_t;

  logic [15:0] amplitude, frequency, near_threshold;
  logic signed [31:0] ab;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude      <= 16'd6144;
      frequency      <= 16'd2048;
      near_threshold <= 16'd41;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AMPLITUDE:      amplitude      <= cfg_data;
        REG_FREQUENCY:      frequency      <= cfg_data;
        REG_NEAR_THRESHOLD: near_threshold <= cfg_data;
        default: ;
      endcase
    end
    ab <= 32'($signed(amplitude)) * 32'($signed(frequency));
  end

  // front: capture, square, sum
  logic        v0, v1, v2;
  item_t       it0, it1, it2;
  logic signed [31:0] uu1, vv1;
  logic [31:0] sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
      v2 <= v1;
    end
    it0  <= item;
    uu1  <= 32'(it0.u_coord) * 32'(it0.u_coord);
    vv1  <= 32'(it0.v_coord) * 32'(it0.v_coord);
    it1  <= it0;
    sum2 <= 32'(uu1) + 32'(vv1);
    it2  <= it1;
  end

  logic        sq_v;
  logic [15:0] sq_r;
  item_t       sq_it;

  cwse_sqrt #(.SW($bits(item_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .n        (sum2),
    .side_in  (it2),
    .out_valid(sq_v),
    .root     (sq_r),
    .side_out (sq_it)
  );

  logic               v3;
  logic signed [32:0] theta3;
  geo_t               geo3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= sq_v;
    end
    theta3      <= 33'($signed(frequency)) * $signed({17'd0, sq_r});
    geo3.item   <= sq_it;
    geo3.radius <= sq_r;
  end

  logic               an_v;
  logic signed [CW-1:0] an_cos, an_sin;
  geo_t               an_geo;

  cwse_angle #(.STEPS(CORDIC_STEPS), .SW($bits(geo_t))) u_angle (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .theta    (theta3),
    .side_in  (geo3),
    .out_valid(an_v),
    .cos_q    (an_cos),
    .sin_q    (an_sin),
    .side_out (an_geo)
  );

  logic               v4, v5, v6, v7;
  logic signed [49:0] pzp4;
  logic signed [65:0] asp4;
  geo_t               geo4, geo5, geo6;
  logic signed [31:0] pz5, pz6;
  logic signed [32:0] s5;
  logic signed [NU_W-1:0] nu6, nv6;
  logic signed [63:0] pz_rnd;
  logic signed [66:0] s_rnd;

  assign pz_rnd = (64'(pzp4) + (64'sd1 <<< 29)) >>> 30;
  assign s_rnd  = (67'(asp4) + (67'sd1 <<< 29)) >>> 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v4 <= an_v;
      v5 <= v4;
      v6 <= v5;
    end
    pzp4 <= 50'($signed(amplitude)) * 50'(an_cos);
    asp4 <= 66'(ab) * 66'(an_sin);
    geo4 <= an_geo;
    pz5  <= sat32(pz_rnd);
    s5   <= 33'(s_rnd);
    geo5 <= geo4;
    nu6  <= NU_W'(s5) * NU_W'(geo5.item.u_coord);
    nv6  <= NU_W'(s5) * NU_W'(geo5.item.v_coord);
    pz6  <= pz5;
    geo6 <= geo5;
  end

  logic signed [63:0] tu, tv;
  logic [NU_W-1:0]    mag_u, mag_v;
  logic [NU_W:0]      half_d;
  logic [DQ_W-1:0]    dn_u7, dn_v7;
  mid_t               mid7;

  assign tu     = (64'(nu6) + (64'sd1 <<< (TWOF - 1))) >>> TWOF;
  assign tv     = (64'(nv6) + (64'sd1 <<< (TWOF - 1))) >>> TWOF;
  assign mag_u  = NU_W'(nu6[NU_W-1] ? -nu6 : nu6);
  assign mag_v  = NU_W'(nv6[NU_W-1] ? -nv6 : nv6);
  assign half_d = (NU_W+1)'(geo6.radius) << (FRAC_BITS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    dn_u7        <= DQ_W'(((NU_W+1)'(mag_u) + half_d) >> FRAC_BITS);
    dn_v7        <= DQ_W'(((NU_W+1)'(mag_v) + half_d) >> FRAC_BITS);
    mid7.pos_x   <= geo6.item.u_coord;
    mid7.pos_y   <= geo6.item.v_coord;
    mid7.pos_z   <= pz6;
    mid7.radius  <= geo6.radius;
    mid7.tan_u_z <= sat32(-tu);
    mid7.tan_v_z <= sat32(-tv);
    mid7.nx_near <= sat32(tu);
    mid7.ny_near <= sat32(tv);
    mid7.near    <= geo6.radius <= near_threshold;
    mid7.neg_x   <= nu6[NU_W-1];
    mid7.neg_y   <= nv6[NU_W-1];
  end

  logic            dv_v;
  logic [DQ_W-1:0] q_u, q_v;
  mid_t            dmid;

  cwse_div #(.NW(DQ_W), .DW(16), .SW($bits(mid_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v7),
    .num_a    (dn_u7),
    .num_b    (dn_v7),
    .den      (mid7.radius),
    .side_in  (mid7),
    .out_valid(dv_v),
    .quo_a    (q_u),
    .quo_b    (q_v),
    .side_out (dmid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_v;
    end
    result.pos_x       <= dmid.pos_x;
    result.pos_y       <= dmid.pos_y;
    result.pos_z       <= dmid.pos_z;
    result.radius      <= dmid.radius;
    result.tan_u_z     <= dmid.tan_u_z;
    result.tan_v_z     <= dmid.tan_v_z;
    result.norm_x      <= dmid.near ? dmid.nx_near : qsat(dmid.neg_x, 64'(q_u));
    result.norm_y      <= dmid.near ? dmid.ny_near : qsat(dmid.neg_y, 64'(q_v));
    result.norm_z      <= dmid.near ? dmid.radius : NORM_ONE;
    result.near_center <= dmid.near;
  end

endmodule
`default_nettype wire

>>> rtl/cwse_checker.sv
`default_nettype none
module cwse_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input cwse_pkg::result_t result
);
  import cwse_pkg::*;

  a_no_result_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result strobe straight after reset");

  a_near_norm_z: assert property (@(posedge clk) disable iff (rst)
    done && result.near_center |-> result.norm_z == result.radius)
    else $error("near-centre normal z differs from radius");

  a_far_norm_z: assert property (@(posedge clk) disable iff (rst)
    done && !result.near_center |-> result.norm_z == NORM_ONE && result.radius != 16'd0)
    else $error("far normal z not unity or zero radius");

  a_not_busy: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy outside reset");

endmodule

bind cosine_wave_surface_eval cwse_checker u_cwse_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .done  (done),
  .result(result)
);
`default_nettype wire

>>> tb/sv/cosine_wave_surface_eval_test.sv
`default_nettype none
module cosine_wave_surface_eval_test;
  import cwse_pkg::*;

  localparam int FB = 12;
  localparam int ANGLE_UP = (2 * FB <= 30) ? 30 - 2 * FB : 0;
  localparam int ANGLE_DN = (2 * FB > 30) ? 2 * FB - 30 : 0;
  localparam int STEPS = 16;
  localparam longint Q30_PI = 64'd3373259426;
  localparam longint Q30_TWO_PI = 64'd6746518852;
  localparam longint Q30_HALF_PI = 64'd1686629713;
  localparam longint Q30_GAIN = 64'd652032874;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;

  localparam longint ARCTAN [0:15] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767};

  typedef struct {
    result_t    val;
    bit         known;
    logic [15:0] known_radius;
    logic       known_near;
  } surface_exp_t;

  typedef struct {
    logic signed [15:0] u;
    logic signed [15:0] v;
    bit                 known;
    logic [15:0]        radius;
    logic               near;
  } point_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic signed [15:0] amp_q = 16'sd6144;
  logic signed [15:0] freq_q = 16'sd2048;
  logic [15:0] thresh_q = 16'd41;

  surface_exp_t surface_q[$];
  bit drive_known = 0;
  logic [15:0] drive_radius = '0;
  logic drive_near = 0;
  bit allow_idle = 1;
  int errors = 0;
  int points_sent = 0;
  int points_checked = 0;
  int quiet = 0;

  cosine_wave_surface_eval u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function automatic longint unsigned int_root(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint quotient_nearest(input longint num, input longint den);
    longint unsigned m, q;
    m = (num < 0) ? longint'(-num) : num;
    q = (m + longint'(den) / 2) / longint'(den);
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void wave_phase(input longint th, output longint c, output longint s);
    longint unsigned m;
    longint p, x, y, nx;
    bit flip;
    m = (th < 0) ? longint'(-th) : th;
    m = (m << ANGLE_UP) >> ANGLE_DN;
    p = longint'(m % Q30_TWO_PI);
    flip = 0;
    x = Q30_GAIN;
    y = 0;
    if (p > Q30_PI) p = p - Q30_TWO_PI;
    if (p > Q30_HALF_PI) begin
      p = p - Q30_PI;
      flip = 1;
    end else if (p < -Q30_HALF_PI) begin
      p = p + Q30_PI;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (p >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        p = p - ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        p = p + ARCTAN[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    if (th < 0) y = -y;
    c = x;
    s = y;
  endfunction

  function automatic result_t surface_point(input item_t it);
    longint u, v, a, b, r, cs, sn, sl, nu, nv, tu, tv, nx, ny, nz;
    logic nr;
    result_t res;
    u = it.u_coord;
    v = it.v_coord;
    a = amp_q;
    b = freq_q;
    r = longint'(int_root(longint'(u * u + v * v)));
    nr = r <= longint'(thresh_q);
    wave_phase(b * r, cs, sn);
    sl = round_shift(a * b * sn, 30);
    nu = sl * u;
    nv = sl * v;
    tu = round_shift(nu, 2 * FB);
    tv = round_shift(nv, 2 * FB);
    if (nr) begin
      nx = tu;
      ny = tv;
      nz = r;
    end else begin
      nx = quotient_nearest(nu, r <<< FB);
      ny = quotient_nearest(nv, r <<< FB);
      nz = 1 << FB;
    end
    res.pos_x = it.u_coord;
    res.pos_y = it.v_coord;
    res.pos_z = 32'(clamp32(round_shift(a * cs, 30)));
    res.radius = 16'(r);
    res.tan_u_z = 32'(clamp32(-tu));
    res.tan_v_z = 32'(clamp32(-tv));
    res.norm_x = 32'(clamp32(nx));
    res.norm_y = 32'(clamp32(ny));
    res.norm_z = 16'(nz);
    res.near_center = nr;
    return res;
  endfunction

  function automatic void report(input string name, input longint e, input longint g);
    if (e != g) begin
      $display("%0t: %s expected %0d got %0d", $time, name, e, g);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    surface_exp_t e;
    if (start && !busy && !rst) begin
      e.val = surface_point(item);
      e.known = drive_known;
      e.known_radius = drive_radius;
      e.known_near = drive_near;
      surface_q.push_back(e);
    end
    if (done && !rst) begin
      if (surface_q.size() == 0) begin
        $display("%0t: unexpected result, expected none got radius %0d", $time,
                 result.radius);
        errors++;
      end else begin
        e = surface_q.pop_front();
        points_checked++;
        report("pos_x", e.val.pos_x, result.pos_x);
        report("pos_y", e.val.pos_y, result.pos_y);
        report("pos_z", e.val.pos_z, result.pos_z);
        report("radius", e.val.radius, result.radius);
        report("tan_u_z", e.val.tan_u_z, result.tan_u_z);
        report("tan_v_z", e.val.tan_v_z, result.tan_v_z);
        report("norm_x", e.val.norm_x, result.norm_x);
        report("norm_y", e.val.norm_y, result.norm_y);
        report("norm_z", e.val.norm_z, result.norm_z);
        report("near_center", e.val.near_center, result.near_center);
        if (e.known) begin
          report("radius", e.known_radius, result.radius);
          report("near_center", e.known_near, result.near_center);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_point(input item_t it, input bit known, input logic [15:0] kr,
                            input logic kn);
    while (allow_idle && $urandom_range(99) < 19) begin
      start = 0;
      @(negedge clk);
    end
    while (busy) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    item = it;
    drive_known = known;
    drive_radius = kr;
    drive_near = kn;
    points_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AMPLITUDE:      amp_q = val;
      REG_FREQUENCY:      freq_q = val;
      REG_NEAR_THRESHOLD: thresh_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    start = 0;
    while (surface_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic item_t random_point();
    item_t it;
    int span;
    case ($urandom_range(3))
      0: span = 0;
      1: span = 200;
      2: span = 8192;
      default: span = 1;
    endcase
    it.u_coord = 16'($urandom);
    it.v_coord = 16'($urandom);
    if (span > 1) begin
      it.u_coord = 16'($signed($urandom_range(2 * span)) - span);
      it.v_coord = 16'($signed($urandom_range(2 * span)) - span);
    end else if (span == 1) begin
      if ($urandom_range(1)) it.u_coord = 0;
      else it.v_coord = 0;
    end
    return it;
  endfunction

  point_row_t points[] = '{
    '{16'sd0, 16'sd0, 1, 16'd0, 1'b1},
    '{16'sd3, 16'sd4, 1, 16'd5, 1'b1},
    '{16'sd41, 16'sd0, 1, 16'd41, 1'b1},
    '{16'sd42, 16'sd0, 1, 16'd42, 1'b0},
    '{16'sd0, -16'sd42, 1, 16'd42, 1'b0},
    '{16'sd4096, 16'sd0, 1, 16'd4096, 1'b0},
    '{16'sd32767, 16'sd0, 1, 16'd32767, 1'b0},
    '{-16'sd32768, 16'sd0, 1, 16'd32768, 1'b0},
    '{-16'sd32768, -16'sd32768, 1, 16'd46340, 1'b0},
    '{16'sd32767, 16'sd32767, 1, 16'd46339, 1'b0},
    '{16'sd32767, -16'sd32768, 0, 16'd0, 1'b0},
    '{-16'sd1, 16'sd1, 0, 16'd0, 1'b0},
    '{16'sd6434, 16'sd0, 0, 16'd0, 1'b0},
    '{16'sd1234, -16'sd5678, 0, 16'd0, 1'b0},
    '{-16'sd20000, 16'sd15000, 0, 16'd0, 1'b0},
    '{16'sd1, 16'sd0, 0, 16'd0, 1'b0}
  };

  initial begin
    item_t it;
    repeat (10) @(negedge clk);
    rst = 0;
    for (int ph = 0; ph < 6; ph++) begin
      allow_idle = (ph != 2);
      case (ph)
        1: begin
          write_reg(REG_AMPLITUDE, 16'h8000);
          write_reg(REG_FREQUENCY, 16'h7FFF);
          write_reg(REG_NEAR_THRESHOLD, 16'h0000);
        end
        2: begin
          write_reg(REG_AMPLITUDE, 16'h7FFF);
          write_reg(REG_FREQUENCY, 16'h8000);
          write_reg(REG_NEAR_THRESHOLD, 16'hFFFF);
        end
        3: begin
          write_reg(REG_SPARE, 16'($urandom));
          write_reg(REG_AMPLITUDE, 16'($urandom));
          write_reg(REG_FREQUENCY, 16'($urandom));
          write_reg(REG_NEAR_THRESHOLD, 16'($urandom_range(2000)));
        end
        4: begin
          write_reg(REG_AMPLITUDE, 16'($urandom));
          write_reg(REG_FREQUENCY, 16'($urandom));
          write_reg(REG_NEAR_THRESHOLD, 16'($urandom));
        end
        5: begin
          write_reg(REG_AMPLITUDE, 16'h0000);
          write_reg(REG_FREQUENCY, 16'h0000);
          write_reg(REG_NEAR_THRESHOLD, 16'd41);
        end
        default: ;
      endcase
      foreach (points[i]) begin
        it.u_coord = points[i].u;
        it.v_coord = points[i].v;
        send_point(it, points[i].known && ph == 0, points[i].radius, points[i].near);
      end
      for (int n = 0; n < 330; n++) begin
        if (n == 150) drain();
        send_point(random_point(), 0, '0, 1'b0);
      end
      drain();
    end
    $display("covered %0d points over six register settings, %0d results checked",
             points_sent, points_checked);
    if (errors == 0 && surface_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
